### rtl/core/mkaw_pkg.sv
// shared types, codes, constants and the gain table of the mouse-key pointer block
package mkaw_pkg;

    // item kinds on the input and report kinds on the output
    localparam logic [1:0] KIND_MOVE    = 2'd0;
    localparam logic [1:0] KIND_WARP    = 2'd1;
    localparam logic [1:0] KIND_PRESS   = 2'd2;
    localparam logic [1:0] KIND_RELEASE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_FULL_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FULL_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_LEFT = 2'd2;
    localparam logic [1:0] CFG_ORIGIN_TOP  = 2'd3;

    localparam int CFG_W   = 15;
    localparam int COORD_W = 16;
    localparam int STEP_W  = 8;
    localparam int BTN_W   = 8;

    // acceleration counter and carry precision
    localparam int ACTIVE_COUNT_MAX = 255;
    localparam int FRACTION_BITS    = 8;
    localparam int COUNT_W          = $clog2(ACTIVE_COUNT_MAX + 1);
    localparam int ROM_DEPTH        = 1 << COUNT_W;

    // gain is unsigned q4.8, floored at 0.25 and capped at 4095
    localparam int GAIN_W    = 12;
    localparam int GAIN_MIN  = 64;
    localparam int GAIN_MAX  = 4095;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam longint ATAN_Q30 [0:10] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
        64'sd4194283,   64'sd2097149,   64'sd1048576
    };

    typedef logic [ROM_DEPTH-1:0][GAIN_W-1:0] gain_rom_t;

    // one item between the front and the back
    typedef struct packed {
        logic [1:0]               kind;
        logic signed [STEP_W-1:0] step_x;
        logic signed [STEP_W-1:0] step_y;
        logic [GAIN_W-1:0]        gain;
        logic [COORD_W-1:0]       abs_x;
        logic [COORD_W-1:0]       abs_y;
        logic [BTN_W-1:0]         button;
    } mkaw_item_t;

    // magnitude shift that rounds towards zero
    function automatic longint shr_mag(input longint v, input int s);
        longint r;
        if (v >= 0)
            r = v >>> s;
        else
            r = -((-v) >>> s);
        return r;
    endfunction

    // arctangent s-curve gain for one counter value, by integer cordic
    function automatic logic [GAIN_W-1:0] gain_of(input int c);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint a;
        x = 64'sd20 <<< 32;
        y = longint'(c - 100) <<< 32;
        z = 0;
        for (int i = 0; i < 30; i++)
        begin
            dx = shr_mag(x, i);
            dy = shr_mag(y, i);
            a  = (i < 11) ? ATAN_Q30[i] : (64'sd1 <<< (30 - i));
            if (y > 0)
            begin
                x = x + dy;
                y = y - dx;
                z = z + a;
            end
            else
            begin
                x = x - dy;
                y = y + dx;
                z = z - a;
            end
        end
        z = z + HALF_PI_Q30;
        if (z < 0)
            z = 0;
        z = (z * 5 + (64'sd1 <<< 21)) >>> 22;
        if (z < GAIN_MIN)
            z = GAIN_MIN;
        if (z > GAIN_MAX)
            z = GAIN_MAX;
        return GAIN_W'(z);
    endfunction

    // whole gain table, built at elaboration
    function automatic gain_rom_t build_gain_rom();
        gain_rom_t rom;
        for (int c = 0; c < ROM_DEPTH; c++)
        begin
            rom[c] = gain_of(c);
        end
        return rom;
    endfunction

    localparam gain_rom_t GAIN_ROM = build_gain_rom();

endpackage

### rtl/core/mkaw_queue.sv
// two-entry item queue between the front and the back
module mkaw_queue
    import mkaw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  mkaw_item_t push_item,
    output logic       push_ready,
    input  logic       pop,
    output logic       pop_valid,
    output mkaw_item_t pop_item
);

    mkaw_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### rtl/core/mkaw_front.sv
// front end: config registers, item classification, counter, gain lookup and warp region
module mkaw_front
    import mkaw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               kind,
    input  logic signed [STEP_W-1:0] step_x,
    input  logic signed [STEP_W-1:0] step_y,
    input  logic                     warp_up,
    input  logic                     warp_dn,
    input  logic                     warp_lt,
    input  logic                     warp_rt,
    input  logic                     warp_stop,
    input  logic [BTN_W-1:0]         button_code,
    input  logic                     q_ready,
    output logic                     q_push,
    output mkaw_item_t               q_item
);

    logic [CFG_W-1:0]   full_width_reg;
    logic [CFG_W-1:0]   full_height_reg;
    logic [CFG_W-1:0]   origin_left_reg;
    logic [CFG_W-1:0]   origin_top_reg;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COORD_W-1:0] region_left_reg;
    logic [COORD_W-1:0] region_left_next;
    logic [COORD_W-1:0] region_top_reg;
    logic [COORD_W-1:0] region_top_next;
    logic [CFG_W-1:0]   region_width_reg;
    logic [CFG_W-1:0]   region_width_next;
    logic [CFG_W-1:0]   region_height_reg;
    logic [CFG_W-1:0]   region_height_next;
    logic               warping_reg;
    logic               warping_next;

    logic               accept;
    logic [COORD_W-1:0] base_left;
    logic [COORD_W-1:0] base_top;
    logic [CFG_W-1:0]   base_width;
    logic [CFG_W-1:0]   base_height;
    logic [CFG_W-1:0]   half_width;
    logic [CFG_W-1:0]   half_height;
    logic [COORD_W-1:0] new_left;
    logic [COORD_W-1:0] new_top;

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_width_reg  <= CFG_W'(32767);
            full_height_reg <= CFG_W'(32767);
            origin_left_reg <= '0;
            origin_top_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FULL_WIDTH:  full_width_reg  <= cfg_wdata;
                CFG_FULL_HEIGHT: full_height_reg <= cfg_wdata;
                CFG_ORIGIN_LEFT: origin_left_reg <= cfg_wdata;
                CFG_ORIGIN_TOP:  origin_top_reg  <= cfg_wdata;
                default:         full_width_reg  <= full_width_reg;
            endcase
        end
    end

    // region a warp starts from: the live one, or the whole area on warp start
    always_comb
    begin
        if (warping_reg)
        begin
            base_left   = region_left_reg;
            base_top    = region_top_reg;
            base_width  = region_width_reg;
            base_height = region_height_reg;
        end
        else
        begin
            base_left   = COORD_W'(origin_left_reg);
            base_top    = COORD_W'(origin_top_reg);
            base_width  = full_width_reg;
            base_height = full_height_reg;
        end
        half_width  = base_width >> 1;
        half_height = base_height >> 1;
        new_top  = base_top + ((warp_dn && !warp_up) ? COORD_W'(half_height) : '0);
        new_left = base_left + ((warp_rt && !warp_lt) ? COORD_W'(half_width) : '0);
    end

    // classify the item and update front state
    always_comb
    begin
        count_next         = count_reg;
        region_left_next   = region_left_reg;
        region_top_next    = region_top_reg;
        region_width_next  = region_width_reg;
        region_height_next = region_height_reg;
        warping_next       = warping_reg;
        q_push             = 1'b0;
        q_item             = '0;
        q_item.kind        = kind;
        if (accept)
        begin
            case (kind)
                KIND_MOVE:
                begin
                    if (step_x == '0 && step_y == '0)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        if (count_reg < COUNT_W'(ACTIVE_COUNT_MAX))
                            count_next = count_reg + 1'b1;
                        warping_next  = 1'b0;
                        q_push        = 1'b1;
                        q_item.step_x = step_x;
                        q_item.step_y = step_y;
                        q_item.gain   = GAIN_ROM[count_next];
                    end
                end
                KIND_WARP:
                begin
                    region_left_next   = base_left;
                    region_top_next    = base_top;
                    region_width_next  = base_width;
                    region_height_next = base_height;
                    if (warp_stop)
                    begin
                        warping_next = 1'b0;
                    end
                    else
                    begin
                        warping_next       = 1'b1;
                        region_width_next  = half_width;
                        region_height_next = half_height;
                        region_left_next   = new_left;
                        region_top_next    = new_top;
                        q_push             = 1'b1;
                        q_item.abs_x = new_left + COORD_W'(half_width >> 1);
                        q_item.abs_y = new_top + COORD_W'(half_height >> 1);
                    end
                end
                KIND_PRESS:
                begin
                    warping_next  = 1'b0;
                    q_push        = 1'b1;
                    q_item.button = button_code;
                end
                default:
                begin
                    q_push        = 1'b1;
                    q_item.button = button_code;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            region_left_reg   <= '0;
            region_top_reg    <= '0;
            region_width_reg  <= '0;
            region_height_reg <= '0;
            warping_reg       <= 1'b0;
        end
        else
        begin
            count_reg         <= count_next;
            region_left_reg   <= region_left_next;
            region_top_reg    <= region_top_next;
            region_width_reg  <= region_width_next;
            region_height_reg <= region_height_next;
            warping_reg       <= warping_next;
        end
    end

endmodule

### rtl/core/mkaw_back.sv
// back end: per-axis scaling with fraction carry and the output register
module mkaw_back
    import mkaw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  mkaw_item_t               q_item,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               report_kind,
    output logic signed [STEP_W-1:0] move_x,
    output logic signed [STEP_W-1:0] move_y,
    output logic [COORD_W-1:0]       abs_x,
    output logic [COORD_W-1:0]       abs_y,
    output logic [BTN_W-1:0]         button_out
);

    localparam int PROD_W   = STEP_W + GAIN_W;
    localparam int SHL      = (FRACTION_BITS >= 8) ? FRACTION_BITS - 8 : 0;
    localparam int SHR      = (FRACTION_BITS < 8) ? 8 - FRACTION_BITS : 0;
    localparam int SCALED_W = PROD_W + SHL;
    localparam int SUM_W    = SCALED_W + 1;
    localparam int WHOLE_W  = SUM_W - FRACTION_BITS;

    typedef struct packed {
        logic signed [STEP_W-1:0] move;
        logic [FRACTION_BITS-1:0] carry;
    } axis_res_t;

    // scale one axis: magnitude times gain plus carry, saturate, restore sign
    function automatic axis_res_t scale_axis(
        input logic signed [STEP_W-1:0] step,
        input logic [GAIN_W-1:0]        gain,
        input logic [FRACTION_BITS-1:0] carry
    );
        axis_res_t              r;
        logic [STEP_W-1:0]      mag;
        logic [PROD_W-1:0]      prod;
        logic [SCALED_W-1:0]    scaled;
        logic [SUM_W-1:0]       sum;
        logic [WHOLE_W-1:0]     whole;
        logic [STEP_W-1:0]      sat;
        mag    = step[STEP_W-1] ? STEP_W'(-step) : STEP_W'(step);
        prod   = PROD_W'(mag) * PROD_W'(gain);
        scaled = (SCALED_W'(prod) << SHL) >> SHR;
        sum    = SUM_W'(scaled) + SUM_W'(carry);
        whole  = sum[SUM_W-1:FRACTION_BITS];
        sat    = (whole > WHOLE_W'(127)) ? STEP_W'(127) : STEP_W'(whole);
        if (step == '0)
        begin
            r.move  = '0;
            r.carry = carry;
        end
        else
        begin
            r.move  = step[STEP_W-1] ? -$signed(sat) : $signed(sat);
            r.carry = sum[FRACTION_BITS-1:0];
        end
        return r;
    endfunction

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [1:0]               report_kind_reg;
    logic signed [STEP_W-1:0] move_x_reg;
    logic signed [STEP_W-1:0] move_y_reg;
    logic [COORD_W-1:0]       abs_x_reg;
    logic [COORD_W-1:0]       abs_y_reg;
    logic [BTN_W-1:0]         button_reg;
    logic [FRACTION_BITS-1:0] carry_x_reg;
    logic [FRACTION_BITS-1:0] carry_x_next;
    logic [FRACTION_BITS-1:0] carry_y_reg;
    logic [FRACTION_BITS-1:0] carry_y_next;
    axis_res_t                res_x;
    axis_res_t                res_y;
    logic                     is_move;

    // take a queued item whenever the output register is free or draining
    assign q_pop   = q_valid && (!out_valid_reg || out_ready);
    assign is_move = (q_item.kind == KIND_MOVE);
    assign res_x   = scale_axis(q_item.step_x, q_item.gain, carry_x_reg);
    assign res_y   = scale_axis(q_item.step_y, q_item.gain, carry_y_reg);

    // output valid and carry state
    always_comb
    begin
        out_valid_next = out_valid_reg;
        carry_x_next   = carry_x_reg;
        carry_y_next   = carry_y_reg;
        if (q_pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        if (q_pop && is_move)
        begin
            carry_x_next = res_x.carry;
            carry_y_next = res_y.carry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            carry_x_reg   <= '0;
            carry_y_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            carry_x_reg   <= carry_x_next;
            carry_y_reg   <= carry_y_next;
        end
    end

    // report payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            report_kind_reg <= q_item.kind;
            move_x_reg      <= is_move ? res_x.move : '0;
            move_y_reg      <= is_move ? res_y.move : '0;
            abs_x_reg       <= q_item.abs_x;
            abs_y_reg       <= q_item.abs_y;
            button_reg      <= q_item.button;
        end
    end

    assign out_valid   = out_valid_reg;
    assign report_kind = report_kind_reg;
    assign move_x      = move_x_reg;
    assign move_y      = move_y_reg;
    assign abs_x       = abs_x_reg;
    assign abs_y       = abs_y_reg;
    assign button_out  = button_reg;

endmodule

### rtl/core/mouse_key_accel_and_warp_unit.sv
// top level of the mouse-key pointer block: front end, item queue, back end
// an accepted item is held in a queue entry and then in the output register before its report shows on out_valid
// throughput: one item per cycle; the front takes an item while the queue has room
// items that give no report (zero move, warp end) only update front state
// reset: asynchronous, active low; clears counter, carries, region, warp mode,
// queue and output valid, and loads the warp area registers with their defaults
module mouse_key_accel_and_warp_unit
    import mkaw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               kind,
    input  logic signed [STEP_W-1:0] step_x,
    input  logic signed [STEP_W-1:0] step_y,
    input  logic                     warp_up,
    input  logic                     warp_dn,
    input  logic                     warp_lt,
    input  logic                     warp_rt,
    input  logic                     warp_stop,
    input  logic [BTN_W-1:0]         button_code,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               report_kind,
    output logic signed [STEP_W-1:0] move_x,
    output logic signed [STEP_W-1:0] move_y,
    output logic [COORD_W-1:0]       abs_x,
    output logic [COORD_W-1:0]       abs_y,
    output logic [BTN_W-1:0]         button_out
);

    logic       q_push;
    logic       q_ready;
    logic       q_pop;
    logic       q_valid;
    mkaw_item_t push_item;
    mkaw_item_t pop_item;

    // classification and state update
    mkaw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .step_x      (step_x),
        .step_y      (step_y),
        .warp_up     (warp_up),
        .warp_dn     (warp_dn),
        .warp_lt     (warp_lt),
        .warp_rt     (warp_rt),
        .warp_stop   (warp_stop),
        .button_code (button_code),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    // decoupling queue
    mkaw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (pop_item)
    );

    // scaling and report output
    mkaw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .report_kind (report_kind),
        .move_x      (move_x),
        .move_y      (move_y),
        .abs_x       (abs_x),
        .abs_y       (abs_y),
        .button_out  (button_out)
    );

endmodule

### rtl/core/mkaw_checker.sv
// port-level checks of the mouse-key pointer block and their bind
module mkaw_checker
    import mkaw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [1:0]               kind,
    input  logic signed [STEP_W-1:0] step_x,
    input  logic signed [STEP_W-1:0] step_y,
    input  logic                     warp_up,
    input  logic                     warp_dn,
    input  logic                     warp_lt,
    input  logic                     warp_rt,
    input  logic                     warp_stop,
    input  logic [BTN_W-1:0]         button_code,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [1:0]               report_kind,
    input  logic signed [STEP_W-1:0] move_x,
    input  logic signed [STEP_W-1:0] move_y,
    input  logic [COORD_W-1:0]       abs_x,
    input  logic [COORD_W-1:0]       abs_y,
    input  logic [BTN_W-1:0]         button_out
);

    // a stalled report holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(report_kind)
            && $stable(move_x) && $stable(move_y) && $stable(abs_x)
            && $stable(abs_y) && $stable(button_out))
    else $error("stalled report changed");

    // relative motion is saturated to plus or minus 127, with no stray fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_kind == KIND_MOVE
            |-> move_x != -8'sd128 && move_y != -8'sd128
                && abs_x == '0 && abs_y == '0 && button_out == '0)
    else $error("relative report out of range or stray fields");

    // absolute report carries only the centre
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_kind == KIND_WARP
            |-> move_x == '0 && move_y == '0 && button_out == '0)
    else $error("absolute report has stray fields");

    // button reports carry only the button
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (report_kind == KIND_PRESS || report_kind == KIND_RELEASE)
            |-> move_x == '0 && move_y == '0 && abs_x == '0 && abs_y == '0)
    else $error("button report has stray fields");

endmodule

bind mouse_key_accel_and_warp_unit mkaw_checker u_mkaw_checker (.*);
